FILE: rtl/pkxc_pkg.sv
// Shared types, constants and helper functions of the position-keyed XOR byte cipher.
`default_nettype none

package pkxc_pkg;

  // Key geometry.
  localparam int unsigned KEY_BYTES     = 32;
  localparam int unsigned KEY_WORDS     = 4;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned KEY_W         = KEY_WORDS * WORD_W;
  localparam int unsigned IDX_W         = $clog2(KEY_BYTES);
  localparam int unsigned POS_W         = 32;
  localparam int unsigned CFG_IDX_W     = 3;

  // Residue lane 0 counts modulo 12 instead of modulo 0.
  localparam logic [IDX_W-1:0] ZERO_DIV_SUB = IDX_W'(12);

  typedef logic [KEY_W-1:0]                key_t;
  typedef logic [KEY_BYTES-1:0][IDX_W-1:0] res_vec_t;

  // Register map of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_A_WORD0 = 3'd0,
    CFG_KEY_A_WORD1 = 3'd1,
    CFG_KEY_A_WORD2 = 3'd2,
    CFG_KEY_A_WORD3 = 3'd3,
    CFG_KEY_B_WORD0 = 3'd4,
    CFG_KEY_B_WORD1 = 3'd5,
    CFG_KEY_B_WORD2 = 3'd6,
    CFG_KEY_B_WORD3 = 3'd7
  } cfg_idx_t;

  // One input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] result_byte;
    logic       result_last;
  } out_beat_t;

  // Control from the top level to the position counters.
  typedef struct packed {
    logic advance;
    logic last;
  } pos_ctrl_t;

  // Key byte i; byte 0 sits in bits 7:0 of word 0.
  function automatic logic [7:0] key_byte(input key_t key, input logic [IDX_W-1:0] i);
    key_byte = key[{i, 3'b000} +: 8];
  endfunction

  // Modulus of residue lane j.
  function automatic logic [IDX_W-1:0] lane_divisor(input int unsigned j);
    lane_divisor = (j == 0) ? ZERO_DIV_SUB : IDX_W'(j);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pkxc_pos.sv
// Byte position counter and the per-lane residue counters.
`default_nettype none

module pkxc_pos (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pkxc_pkg::pos_ctrl_t        ctrl,
  output logic [7:0]                      pos_low,
  output pkxc_pkg::res_vec_t              residues
);
  import pkxc_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  res_vec_t         res_r, res_nxt;
  logic             clear;

  // A file end or a position wrap sends everything back to zero.
  assign clear = ctrl.last || (pos_r == {POS_W{1'b1}});

  always_comb begin
    logic [IDX_W-1:0] inc;
    inc     = '0;
    pos_nxt = pos_r;
    res_nxt = res_r;
    if (ctrl.advance) begin
      if (clear) begin
        pos_nxt = '0;
        res_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        for (int unsigned j = 0; j < KEY_BYTES; j++) begin
          inc = res_r[j] + IDX_W'(1);
          res_nxt[j] = (inc >= lane_divisor(j)) ? '0 : inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      res_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      res_r <= res_nxt;
    end
  end

  assign pos_low  = pos_r[7:0];
  assign residues = res_r;

  // The power-of-two lanes must track the low position bits.
  a_lane16_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res_r[16] == {1'b0, pos_r[3:0]})
    else $error("residue lane 16 disagrees with position");

  a_lane8_tracks_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res_r[8] == {2'b00, pos_r[2:0]})
    else $error("residue lane 8 disagrees with position");

  // After the final beat of a file the next beat is position zero.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.advance && ctrl.last |=> pos_r == '0 && res_r == '0)
    else $error("position not cleared after file end");

endmodule

`default_nettype wire

FILE: rtl/pkxc_mix.sv
// Keystream byte for the current position, XORed onto the data byte.
`default_nettype none

module pkxc_mix (
  input  wire pkxc_pkg::key_t     key_a,
  input  wire pkxc_pkg::key_t     key_b,
  input  wire logic [7:0]         pos_low,
  input  wire pkxc_pkg::res_vec_t residues,
  input  wire logic [7:0]         data_in,
  output logic [7:0]              data_out
);
  import pkxc_pkg::*;

  logic [7:0]       key_const;
  logic [7:0]       lane_mix;
  logic [IDX_W-1:0] next_idx;

  // XOR of every byte of both keys.
  always_comb begin
    key_const = '0;
    for (int unsigned i = 0; i < KEY_BYTES; i++) begin
      key_const ^= key_byte(key_a, IDX_W'(i)) ^ key_byte(key_b, IDX_W'(i));
    end
  end

  // Each lane picks the first-key byte at its residue.
  always_comb begin
    lane_mix = '0;
    for (int unsigned j = 0; j < KEY_BYTES; j++) begin
      lane_mix ^= key_byte(key_a, residues[j]);
    end
  end

  assign next_idx = pos_low[IDX_W-1:0] + IDX_W'(1);

  assign data_out = data_in ^ key_byte(key_b, next_idx) ^ pos_low ^ key_const ^ lane_mix;

endmodule

`default_nettype wire

FILE: rtl/position_keyed_xor_byte_cipher_top.sv
// Top level of the position-keyed XOR byte cipher.
//
// The block ciphers a stream of file bytes, one result beat per input beat.
// The transform is its own inverse, so one block both encrypts and decrypts.
// Input beats carry a data byte and a last-byte flag; after a beat with the
// flag set the next beat is position zero of a new file. The position also
// restarts after 2^32 bytes.
// The two 32-byte keys are loaded through the cfg_ port, four 64-bit words
// each, byte 0 in bits 7:0 of word 0. Load them only while no beat is in
// flight.
// The result of an accepted beat is registered and shows on out_ in the next cycle.
// Throughput is one beat per cycle while out_stall is low, set by the single output register.
// A stalled result holds in the output register; in_stall rises only while
// that register is full and out_stall is high, so no beat is lost.
// Reset clears the keys, the position and the output valid.
`default_nettype none

module position_keyed_xor_byte_cipher_top (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire pkxc_pkg::in_beat_t                     in_beat,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output pkxc_pkg::out_beat_t                         out_beat,
  input  wire logic                                   cfg_we,
  input  wire logic [pkxc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [pkxc_pkg::WORD_W-1:0]            cfg_wdata
);
  import pkxc_pkg::*;

  logic [KEY_WORDS-1:0][WORD_W-1:0] key_a_r, key_a_nxt;
  logic [KEY_WORDS-1:0][WORD_W-1:0] key_b_r, key_b_nxt;
  logic                             out_valid_r, out_valid_nxt;
  out_beat_t                        out_beat_r, out_beat_nxt;
  logic                             in_take;
  pos_ctrl_t                        pos_ctrl;
  logic [7:0]                       pos_low;
  res_vec_t                         residues;
  logic [7:0]                       mixed;

  // Key register decode.
  always_comb begin
    key_a_nxt = key_a_r;
    key_b_nxt = key_b_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_A_WORD0: key_a_nxt[0] = cfg_wdata;
        CFG_KEY_A_WORD1: key_a_nxt[1] = cfg_wdata;
        CFG_KEY_A_WORD2: key_a_nxt[2] = cfg_wdata;
        CFG_KEY_A_WORD3: key_a_nxt[3] = cfg_wdata;
        CFG_KEY_B_WORD0: key_b_nxt[0] = cfg_wdata;
        CFG_KEY_B_WORD1: key_b_nxt[1] = cfg_wdata;
        CFG_KEY_B_WORD2: key_b_nxt[2] = cfg_wdata;
        CFG_KEY_B_WORD3: key_b_nxt[3] = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= '0;
      key_b_r <= '0;
    end else begin
      key_a_r <= key_a_nxt;
      key_b_r <= key_b_nxt;
    end
  end

  // Input handshake: take a beat whenever the output register frees up.
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  assign pos_ctrl.advance = in_take;
  assign pos_ctrl.last    = in_beat.last_byte;

  pkxc_pos u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (pos_ctrl),
    .pos_low  (pos_low),
    .residues (residues)
  );

  pkxc_mix u_mix (
    .key_a    (key_t'(key_a_r)),
    .key_b    (key_t'(key_b_r)),
    .pos_low  (pos_low),
    .residues (residues),
    .data_in  (in_beat.data_byte),
    .data_out (mixed)
  );

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    if (in_take) begin
      out_valid_nxt            = 1'b1;
      out_beat_nxt.result_byte = mixed;
      out_beat_nxt.result_last = in_beat.last_byte;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_beat_r <= out_beat_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Every accepted beat leaves a result in the output register.
  a_take_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("accepted beat did not reach the output register");

  // A held result is not overwritten.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !in_take)
    else $error("input taken while output register is held");

  // A stalled result stays valid and unchanged until it is taken.
  a_held_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_beat_r))
    else $error("stalled result changed before it was taken");

endmodule

`default_nettype wire
